// ===== rtl/sad_template_digit_matcher_defines.svh =====
// Assertion macros for the digit matcher.
`ifndef SAD_TEMPLATE_DIGIT_MATCHER_DEFINES_SVH
`define SAD_TEMPLATE_DIGIT_MATCHER_DEFINES_SVH
`ifndef SYNTH
`define SADM_ASSERT_NEVER(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("assertion failed: forbidden condition seen");
`define SADM_ASSERT_DELAY(label, ante, n, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##n (cons)) \
		else $error("assertion failed: expected follow-up missing");
`else
`define SADM_ASSERT_NEVER(label, cond)
`define SADM_ASSERT_DELAY(label, ante, n, cons)
`endif
`endif

// ===== rtl/sadm_pkg.sv =====
package sadm_pkg;

	localparam int PIXEL_W = 8;
	localparam int SUM_W = 19;
	localparam int DIGIT_W = 4;
	localparam int PIXEL_INDEX_W = 11;

	localparam int TEMPLATE_COUNT_DEF = 10;
	localparam int IMAGE_WIDTH_DEF = 32;
	localparam int IMAGE_HEIGHT_DEF = 48;
	localparam int QUEUE_DEPTH = 4;
	localparam int RESULT_DEPTH = 4;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_MATCH = 1'b1;

	typedef struct packed {
		logic                     command;
		logic [DIGIT_W-1:0]       template_index;
		logic [PIXEL_INDEX_W-1:0] pixel_index;
		logic [PIXEL_W-1:0]       pixel;
		logic                     last_pixel;
	} item_t;

	typedef struct packed {
		logic [DIGIT_W-1:0] best_digit;
		logic [SUM_W-1:0]   best_sum;
	} result_t;

	typedef struct packed {
		logic                     is_match;
		logic                     add_en;
		logic                     last;
		logic [DIGIT_W-1:0]       bank;
		logic [PIXEL_INDEX_W-1:0] addr;
		logic [PIXEL_W-1:0]       pixel;
	} op_t;

	typedef struct packed {
		logic pop;
		logic pop_last;
		logic res_push;
	} back_stat_t;

endpackage

// ===== rtl/sad_template_digit_matcher.sv =====
// Classifies an image against stored digit templates by sum of absolute differences.
// Template loads and image pixels are both taken at one beat per clock through a
// four-entry command queue, sustained except while a last pixel waits for result room.
// The template store is one RAM bank per template with one write and one read port. A
// result is pushed to the result queue after the last image pixel leaves the command
// queue, passing the bank read register, the sums update and a two-level registered
// minimum search. The command queue stops draining a last pixel only while the
// four-entry result queue is fully reserved by results not yet taken. The template store
// has no reset; every position must be loaded before it is matched against.
`include "sad_template_digit_matcher_defines.svh"

module sad_template_digit_matcher #(
	parameter int TEMPLATE_COUNT = sadm_pkg::TEMPLATE_COUNT_DEF,
	parameter int IMAGE_WIDTH = sadm_pkg::IMAGE_WIDTH_DEF,
	parameter int IMAGE_HEIGHT = sadm_pkg::IMAGE_HEIGHT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  sadm_pkg::item_t   item,
	output logic              empty,
	input  logic              pop,
	output sadm_pkg::result_t result
);

	localparam int PIXEL_COUNT = IMAGE_WIDTH * IMAGE_HEIGHT;
	localparam int RD = sadm_pkg::RESULT_DEPTH;
	localparam int RCW = $clog2(RD + 1);

	sadm_pkg::op_t op;
	sadm_pkg::op_t head;
	logic q_push;
	logic q_full;
	logic q_empty;
	sadm_pkg::back_stat_t stat;
	sadm_pkg::result_t res;
	logic res_full;
	logic res_pop;
	logic [RCW-1:0] pend_q;

	sadm_front #(
		.TEMPLATE_COUNT(TEMPLATE_COUNT),
		.PIXEL_COUNT(PIXEL_COUNT)
	) u_front (
		.push(push),
		.full(full),
		.item(item),
		.q_full(q_full),
		.q_push(q_push),
		.op(op)
	);

	sadm_queue #(
		.T(sadm_pkg::op_t),
		.DEPTH(sadm_pkg::QUEUE_DEPTH)
	) u_cmd_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(q_push),
		.wr_data(op),
		.rd_en(stat.pop),
		.rd_data(head),
		.full(q_full),
		.empty(q_empty)
	);

	sadm_back #(
		.TEMPLATE_COUNT(TEMPLATE_COUNT),
		.PIXEL_COUNT(PIXEL_COUNT)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.head_valid(!q_empty),
		.res_room(pend_q < RCW'(RD)),
		.stat(stat),
		.res(res)
	);

	sadm_queue #(
		.T(sadm_pkg::result_t),
		.DEPTH(RD)
	) u_res_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(stat.res_push),
		.wr_data(res),
		.rd_en(pop),
		.rd_data(result),
		.full(res_full),
		.empty(empty)
	);

	assign res_pop = pop && !empty;

	// Result slots reserved from the moment a last pixel leaves the command queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (stat.pop_last && !res_pop) begin
			pend_q <= pend_q + 1'b1;
		end else if (res_pop && !stat.pop_last) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	`SADM_ASSERT_NEVER(a_res_overflow, stat.res_push && res_full)
	`SADM_ASSERT_DELAY(a_res_latency, stat.pop_last, 3, stat.res_push)
	`SADM_ASSERT_NEVER(a_pend_range, pend_q > RCW'(RD))

endmodule

// ===== rtl/sadm_queue.sv =====
module sadm_queue #(
	parameter type T = logic,
	parameter int DEPTH = sadm_pkg::QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  T     wr_data,
	input  logic rd_en,
	output T     rd_data,
	output logic full,
	output logic empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	T mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic do_wr;
	logic do_rd;

	assign full = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/sadm_front.sv =====
module sadm_front #(
	parameter int TEMPLATE_COUNT = sadm_pkg::TEMPLATE_COUNT_DEF,
	parameter int PIXEL_COUNT = sadm_pkg::IMAGE_WIDTH_DEF * sadm_pkg::IMAGE_HEIGHT_DEF
) (
	input  logic           push,
	output logic           full,
	input  sadm_pkg::item_t item,
	input  logic           q_full,
	output logic           q_push,
	output sadm_pkg::op_t  op
);

	logic pos_ok;
	logic tidx_ok;
	logic keep;

	assign pos_ok = 32'(item.pixel_index) < 32'(PIXEL_COUNT);
	assign tidx_ok = 32'(item.template_index) < 32'(TEMPLATE_COUNT);

	// Beats that change nothing are taken and dropped here.
	always_comb begin
		op.is_match = (item.command == sadm_pkg::CMD_MATCH);
		op.add_en = pos_ok;
		op.last = op.is_match && item.last_pixel;
		op.bank = item.template_index;
		op.addr = item.pixel_index;
		op.pixel = item.pixel;
		if (op.is_match) begin
			keep = pos_ok || item.last_pixel;
		end else begin
			keep = pos_ok && tidx_ok;
		end
	end

	assign full = q_full;
	assign q_push = push && !q_full && keep;

endmodule

// ===== rtl/sadm_back.sv =====
module sadm_back #(
	parameter int TEMPLATE_COUNT = sadm_pkg::TEMPLATE_COUNT_DEF,
	parameter int PIXEL_COUNT = sadm_pkg::IMAGE_WIDTH_DEF * sadm_pkg::IMAGE_HEIGHT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sadm_pkg::op_t        head,
	input  logic                 head_valid,
	input  logic                 res_room,
	output sadm_pkg::back_stat_t stat,
	output sadm_pkg::result_t    res
);

	localparam int AW = $clog2(PIXEL_COUNT);
	localparam int NG = (TEMPLATE_COUNT + 3) / 4;
	localparam int SW = sadm_pkg::SUM_W;
	localparam int PW = sadm_pkg::PIXEL_W;
	localparam int DW = sadm_pkg::DIGIT_W;

	logic [AW-1:0] head_addr;
	logic pop;
	logic rd_en;

	logic v_s1;
	logic last_s1;
	logic add_s1;
	logic [PW-1:0] pix_s1;
	logic [PW-1:0] rd_s1 [TEMPLATE_COUNT];

	logic [SW-1:0] sums_q [TEMPLATE_COUNT];
	logic [SW-1:0] acc [TEMPLATE_COUNT];

	logic v_s2;
	logic [SW-1:0] fin_s2 [TEMPLATE_COUNT];

	logic v_s3;
	logic [SW-1:0] grp_sum_s3 [NG];
	logic [DW-1:0] grp_idx_s3 [NG];
	logic [SW-1:0] grp_sum [NG];
	logic [DW-1:0] grp_idx [NG];

	assign head_addr = AW'(head.addr);
	assign pop = head_valid && (!head.last || res_room);
	assign rd_en = pop && head.is_match;

	assign stat.pop = pop;
	assign stat.pop_last = pop && head.last;
	assign stat.res_push = v_s3;

	// One template bank per digit, so every bank is read at the same position.
	for (genvar t = 0; t < TEMPLATE_COUNT; t++) begin : g_bank
		logic [PW-1:0] bank_mem [PIXEL_COUNT];
		logic wr_en;

		assign wr_en = pop && !head.is_match && (head.bank == DW'(t));

		always_ff @(posedge clk) begin
			if (wr_en) begin
				bank_mem[head_addr] <= head.pixel;
			end
			if (rd_en) begin
				rd_s1[t] <= bank_mem[head_addr];
			end
		end
	end

	always_comb begin
		logic [PW-1:0] d;
		logic [SW:0] s;
		for (int t = 0; t < TEMPLATE_COUNT; t++) begin
			d = (pix_s1 > rd_s1[t]) ? pix_s1 - rd_s1[t] : rd_s1[t] - pix_s1;
			s = {1'b0, sums_q[t]} + (SW + 1)'(d);
			if (!add_s1) begin
				acc[t] = sums_q[t];
			end else if (s[SW]) begin
				acc[t] = '1;
			end else begin
				acc[t] = s[SW-1:0];
			end
		end
	end

	// Minimum within groups of four; strict less keeps the lowest index on a tie.
	always_comb begin
		logic [SW-1:0] best;
		logic [DW-1:0] idx;
		for (int g = 0; g < NG; g++) begin
			best = fin_s2[g * 4];
			idx = DW'(g * 4);
			for (int k = 1; k < 4; k++) begin
				if ((g * 4 + k < TEMPLATE_COUNT) && (fin_s2[g * 4 + k] < best)) begin
					best = fin_s2[g * 4 + k];
					idx = DW'(g * 4 + k);
				end
			end
			grp_sum[g] = best;
			grp_idx[g] = idx;
		end
	end

	always_comb begin
		res.best_sum = grp_sum_s3[0];
		res.best_digit = grp_idx_s3[0];
		for (int g = 1; g < NG; g++) begin
			if (grp_sum_s3[g] < res.best_sum) begin
				res.best_sum = grp_sum_s3[g];
				res.best_digit = grp_idx_s3[g];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			for (int t = 0; t < TEMPLATE_COUNT; t++) begin
				sums_q[t] <= '0;
			end
		end else begin
			v_s1 <= rd_en;
			v_s2 <= v_s1 && last_s1;
			v_s3 <= v_s2;
			if (v_s1) begin
				for (int t = 0; t < TEMPLATE_COUNT; t++) begin
					sums_q[t] <= last_s1 ? '0 : acc[t];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			last_s1 <= head.last;
			add_s1 <= head.add_en;
			pix_s1 <= head.pixel;
		end
		if (v_s1 && last_s1) begin
			for (int t = 0; t < TEMPLATE_COUNT; t++) begin
				fin_s2[t] <= acc[t];
			end
		end
		if (v_s2) begin
			for (int g = 0; g < NG; g++) begin
				grp_sum_s3[g] <= grp_sum[g];
				grp_idx_s3[g] <= grp_idx[g];
			end
		end
	end

endmodule
